// File: hdl/bfsf_pkg.sv
// Shared types, constants and command/status structs for the bitmap free-slot finder.
`timescale 1ns / 1ps

package bfsf_pkg;

    localparam int BFSF_WORD_BITS = 32;
    localparam int BFSF_MAX_WORDS = 1024;

    localparam int MAP_W = 16;
    localparam int IDX_W = 15;
    localparam int OP_W  = 3;

    localparam logic [MAP_W-1:0] MAP_BITS_RST = 16'd32768;

    typedef enum logic [OP_W-1:0] {
        OP_READ  = 3'd0,
        OP_WRITE = 3'd1,
        OP_CLEAR = 3'd2,
        OP_SET   = 3'd3,
        OP_FIRST = 3'd4,
        OP_NEXT  = 3'd5
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV1,
        S_DIV2,
        S_DECIDE,
        S_RD_ISSUE,
        S_RD_DATA,
        S_FILL,
        S_SCAN,
        S_RESP
    } t_state;

    typedef struct packed {
        logic capture;
        logic fill_start;
        logic fill_run;
        logic scan_start;
        logic scan_run;
        logic rd_issue;
        logic rd_data;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic oor;
        logic fill_done;
        logic scan_hit;
        logic scan_empty;
    } t_sts;

endpackage

// File: hdl/bfsf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bfsf_ram
    import bfsf_pkg::*;
#(
    parameter int WIDTH = BFSF_WORD_BITS,
    parameter int DEPTH = BFSF_MAX_WORDS
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/bfsf_ctrl.sv
// Operation sequencer: state machine issuing commands to the datapath.
`timescale 1ns / 1ps

module bfsf_ctrl
    import bfsf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    output logic o_out_valid,
    input  logic i_out_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DIV1;
                end
            end
            S_DIV1:   n_state = S_DIV2;
            S_DIV2:   n_state = S_DECIDE;
            S_DECIDE: begin
                unique case (i_sts.op) inside
                    OP_READ, OP_WRITE: n_state = i_sts.oor ? S_RESP : S_RD_ISSUE;
                    OP_CLEAR, OP_SET:  n_state = S_FILL;
                    OP_FIRST:          n_state = S_SCAN;
                    OP_NEXT:           n_state = i_sts.oor ? S_RESP : S_SCAN;
                    default:           n_state = S_RESP;
                endcase
            end
            S_RD_ISSUE: n_state = S_RD_DATA;
            S_RD_DATA:  n_state = S_RESP;
            S_FILL: begin
                if (i_sts.fill_done) begin
                    n_state = S_RESP;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_hit || i_sts.scan_empty) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd            = '0;
        o_in_stall       = (r_state != S_IDLE);
        o_cmd.capture    = (r_state == S_IDLE) && i_in_valid;
        o_cmd.fill_start = (r_state == S_DECIDE)
                           && ((i_sts.op == OP_CLEAR) || (i_sts.op == OP_SET));
        o_cmd.scan_start = (r_state == S_DECIDE)
                           && ((i_sts.op == OP_FIRST) || ((i_sts.op == OP_NEXT) && !i_sts.oor));
        o_cmd.fill_run   = (r_state == S_FILL);
        o_cmd.scan_run   = (r_state == S_SCAN);
        o_cmd.rd_issue   = (r_state == S_RD_ISSUE);
        o_cmd.rd_data    = (r_state == S_RD_DATA);
        o_cmd.out_load   = (r_state == S_RESP) && w_out_free;
        n_out_valid      = o_cmd.out_load || (r_out_valid && i_out_stall);
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_DIV1))
        else $error("accepted item did not start the index split");

    a_result_from_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_RESP))
        else $error("result presented outside the response state");
`endif

endmodule

// File: hdl/bfsf_dp.sv
// Datapath: index split, bitmap RAM, fill sweep, word scan and result registers.
`timescale 1ns / 1ps

module bfsf_dp
    import bfsf_pkg::*;
#(
    parameter int WORD_BITS = BFSF_WORD_BITS,
    parameter int MAX_WORDS = BFSF_MAX_WORDS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [OP_W-1:0]  i_op,
    input  logic [IDX_W-1:0] i_bit_index,
    input  logic             i_write_value,
    input  logic             i_cfg_valid,
    input  logic [MAP_W-1:0] i_cfg_data,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    output logic             o_read_bit,
    output logic [MAP_W-1:0] o_found_index,
    output logic             o_found,
    output logic             o_status
);

    localparam int AW     = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int UW     = $clog2(MAX_WORDS + 1);
    localparam int LW     = UW + 1;
    localparam int OW     = $clog2(WORD_BITS);
    localparam int DIV_SH = 24;
    localparam int PW     = DIV_SH + MAP_W;

    // floor(2^DIV_SH / WORD_BITS): estimate is exact or one low for 16-bit values
    localparam logic [PW-1:0]    RECIP = PW'((1 << DIV_SH) / WORD_BITS);
    localparam logic [MAP_W-1:0] WB16  = MAP_W'(WORD_BITS);
    localparam logic [MAP_W:0]   MAXW  = (MAP_W + 1)'(MAX_WORDS);

    // item and configuration
    logic [MAP_W-1:0] r_map_bits;
    t_op              r_op;
    logic [IDX_W-1:0] r_idx;
    logic             r_wv;

    // index split
    logic [PW-1:0]    w_prod_idx;
    logic [PW-1:0]    w_prod_map;
    logic [MAP_W-1:0] r_qe_idx;
    logic [MAP_W-1:0] r_qe_map;
    logic [MAP_W-1:0] w_rem_idx;
    logic [MAP_W-1:0] w_rem_map;
    logic [MAP_W-1:0] r_word;
    logic [OW-1:0]    r_off;
    logic [MAP_W-1:0] r_mapq;
    logic [UW-1:0]    w_uw;
    logic             w_oor;
    logic             w_in_used;

    // sweep / scan
    logic [AW-1:0]    r_addr;
    logic [MAP_W-1:0] r_base;
    logic [LW-1:0]    r_left;
    logic             r_first;
    logic             r_mode_next;
    logic [UW-1:0]    w_addr_inc;
    logic             w_wrap;
    logic [AW-1:0]    w_addr_nx;
    logic [MAP_W-1:0] w_base_nx;
    logic             w_issue;
    logic             w_fill_we;

    // word evaluation
    logic             r_tg_valid;
    logic [MAP_W-1:0] r_tg_base;
    logic             r_tg_lo;
    logic             r_tg_hi;
    logic [WORD_BITS-1:0] w_mask;
    logic [WORD_BITS-1:0] w_free;
    logic [OW-1:0]    w_pos;
    logic             w_ev_hit;
    logic [MAP_W-1:0] w_ev_idx;
    logic             r_hit;
    logic [MAP_W-1:0] r_hit_idx;
    logic             r_bit;

    // RAM ports
    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    logic [WORD_BITS-1:0] w_wdata;
    logic                 w_re;
    logic [AW-1:0]        w_raddr;
    logic [WORD_BITS-1:0] w_rdata;
    logic [WORD_BITS-1:0] w_rmw;

    // result
    logic             w_res_bit;
    logic [MAP_W-1:0] w_res_idx;
    logic             w_res_found;
    logic             w_res_status;

    // index split: reciprocal estimate, then one correction step
    assign w_prod_idx = PW'(r_idx) * RECIP;
    assign w_prod_map = PW'(r_map_bits) * RECIP;
    assign w_rem_idx  = MAP_W'(r_idx) - r_qe_idx * WB16;
    assign w_rem_map  = r_map_bits - r_qe_map * WB16;

    assign w_uw      = ({1'b0, r_mapq} >= MAXW) ? UW'(MAX_WORDS) : UW'(r_mapq);
    assign w_oor     = (MAP_W'(r_idx) >= r_map_bits) || ({1'b0, r_word} >= MAXW);
    assign w_in_used = ({1'b0, r_word} < (MAP_W + 1)'(w_uw));

    // address walk, wrapping at the end of the used words
    assign w_addr_inc = UW'(r_addr) + UW'(1);
    assign w_wrap     = (w_addr_inc == w_uw);
    assign w_addr_nx  = w_wrap ? '0 : AW'(w_addr_inc);
    assign w_base_nx  = w_wrap ? '0 : (r_base + WB16);

    // evaluation of the word read in the previous cycle
    always_comb begin
        w_mask = '1;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (r_tg_lo) begin
                w_mask[i] = (OW'(i) > r_off);
            end else if (r_tg_hi) begin
                w_mask[i] = !(OW'(i) > r_off);
            end
        end
    end

    assign w_free = ~w_rdata & w_mask;

    always_comb begin
        w_pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (w_free[i]) begin
                w_pos = OW'(i);
            end
        end
    end

    assign w_ev_hit = r_tg_valid && (|w_free);
    assign w_ev_idx = r_tg_base + MAP_W'(w_pos);

    assign w_issue   = i_cmd.scan_run && (r_left != '0) && !w_ev_hit;
    assign w_fill_we = i_cmd.fill_run && (r_left != '0);

    always_comb begin
        w_rmw        = w_rdata;
        w_rmw[r_off] = r_wv;
    end

    assign w_re    = w_issue || i_cmd.rd_issue;
    assign w_raddr = i_cmd.rd_issue ? r_word[AW-1:0] : r_addr;
    assign w_we    = w_fill_we || (i_cmd.rd_data && (r_op == OP_WRITE));
    assign w_waddr = i_cmd.rd_data ? r_word[AW-1:0] : r_addr;
    assign w_wdata = i_cmd.rd_data ? w_rmw : ((r_op == OP_SET) ? '1 : '0);

    bfsf_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAX_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_bits <= MAP_BITS_RST;
            r_left     <= '0;
            r_tg_valid <= 1'b0;
            r_hit      <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_map_bits <= i_cfg_data;
            end
            r_tg_valid <= w_issue;
            if (i_cmd.capture) begin
                r_hit <= 1'b0;
            end else if (w_ev_hit) begin
                r_hit <= 1'b1;
            end
            if (i_cmd.fill_start) begin
                r_left <= LW'(w_uw);
            end else if (i_cmd.scan_start) begin
                r_left <= ((r_op == OP_NEXT) && w_in_used) ? (LW'(w_uw) + LW'(1)) : LW'(w_uw);
            end else if (w_issue || w_fill_we) begin
                r_left <= r_left - LW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= t_op'(i_op);
            r_idx <= i_bit_index;
            r_wv  <= i_write_value;
        end

        r_qe_idx <= w_prod_idx[DIV_SH +: MAP_W];
        r_qe_map <= w_prod_map[DIV_SH +: MAP_W];
        if (w_rem_idx >= WB16) begin
            r_word <= r_qe_idx + MAP_W'(1);
            r_off  <= OW'(w_rem_idx - WB16);
        end else begin
            r_word <= r_qe_idx;
            r_off  <= OW'(w_rem_idx);
        end
        r_mapq <= (w_rem_map >= WB16) ? (r_qe_map + MAP_W'(1)) : r_qe_map;

        if (i_cmd.fill_start) begin
            r_addr <= '0;
            r_base <= '0;
        end else if (i_cmd.scan_start) begin
            r_first <= 1'b1;
            if ((r_op == OP_NEXT) && w_in_used) begin
                r_addr      <= r_word[AW-1:0];
                r_base      <= MAP_W'(r_idx) - MAP_W'(r_off);
                r_mode_next <= 1'b1;
            end else begin
                r_addr      <= '0;
                r_base      <= '0;
                r_mode_next <= 1'b0;
            end
        end else if (w_issue || w_fill_we) begin
            r_addr  <= w_addr_nx;
            r_base  <= w_base_nx;
            r_first <= 1'b0;
        end

        if (w_issue) begin
            r_tg_base <= r_base;
            r_tg_lo   <= r_mode_next && r_first;
            r_tg_hi   <= r_mode_next && (r_left == LW'(1));
        end
        if (w_ev_hit) begin
            r_hit_idx <= w_ev_idx;
        end
        if (i_cmd.rd_data) begin
            r_bit <= w_rdata[r_off];
        end
        if (i_cmd.out_load) begin
            o_read_bit    <= w_res_bit;
            o_found_index <= w_res_idx;
            o_found       <= w_res_found;
            o_status      <= w_res_status;
        end
    end

    always_comb begin
        w_res_bit    = 1'b0;
        w_res_idx    = '0;
        w_res_found  = 1'b0;
        w_res_status = 1'b0;
        case (r_op) inside
            OP_READ: begin
                w_res_status = w_oor;
                w_res_bit    = !w_oor && r_bit;
            end
            OP_WRITE: begin
                w_res_status = w_oor;
            end
            OP_FIRST: begin
                w_res_found = r_hit;
                w_res_idx   = r_hit ? r_hit_idx : r_map_bits;
            end
            OP_NEXT: begin
                w_res_status = w_oor;
                w_res_found  = r_hit;
                w_res_idx    = r_hit ? r_hit_idx : MAP_W'(r_idx);
            end
            default: begin
                w_res_bit = 1'b0;
            end
        endcase
    end

    always_comb begin
        o_sts            = '0;
        o_sts.op         = r_op;
        o_sts.oor        = w_oor;
        o_sts.fill_done  = (r_left == '0);
        o_sts.scan_hit   = w_ev_hit;
        o_sts.scan_empty = (r_left == '0) && !r_tg_valid;
    end

`ifndef SYNTHESIS
    a_tag_follows_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tg_valid |-> $past(i_cmd.scan_run))
        else $error("word evaluated without a scan read the cycle before");

    a_fill_counts_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fill_we |=> (r_left == ($past(r_left) - LW'(1))))
        else $error("fill sweep word count did not step by one");
`endif

endmodule

// File: hdl/bitmap_free_slot_finder.sv
// Top level of the bitmap free-slot finder: sequencer, datapath and ports.
`timescale 1ns / 1ps

// Allocation bitmap of MAX_WORDS words of WORD_BITS bits held in one RAM; a zero
// bit is free. Each input item is one operation (read, write, clear all, set
// all, find first free, find next free with wrap). Only whole words below
// map_bits take part in clearing, setting and searching. The RAM powers up
// undefined and has no clearing pass: software must clear or set the map before
// reading or searching it. Items are handled one at a time. Every item passes
// through the sequencer's idle state (in which the item is taken), the index
// split into word and offset (S_DIV1, S_DIV2), decode and response; an in-range
// read or write adds a RAM read, then a read-modify-write, a clear or set adds a
// sweep over the used words and a check that the sweep has finished, and a
// search adds a read of each word visited plus the registered RAM read, since
// the single RAM read port delivers one word a cycle; when no free bit turns up,
// the last word read must drain. Find first visits at most used_words words,
// find next at most used_words + 1. The result sits in an output register, so
// the next item is taken as soon as the sequencer is back in idle, even while
// the previous result is still stalled. map_bits may be written only while no
// item is in flight; the configuration port is always ready.
module bitmap_free_slot_finder
    import bfsf_pkg::*;
#(
    parameter int WORD_BITS = BFSF_WORD_BITS,
    parameter int MAX_WORDS = BFSF_MAX_WORDS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // item input
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [OP_W-1:0]  i_op,
    input  logic [IDX_W-1:0] i_bit_index,
    input  logic             i_write_value,
    // result output
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic             o_read_bit,
    output logic [MAP_W-1:0] o_found_index,
    output logic             o_found,
    output logic             o_status,
    // map_bits register write
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [MAP_W-1:0] i_cfg_data
);

    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    bfsf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    bfsf_dp #(
        .WORD_BITS (WORD_BITS),
        .MAX_WORDS (MAX_WORDS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (i_op),
        .i_bit_index   (i_bit_index),
        .i_write_value (i_write_value),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_read_bit    (o_read_bit),
        .o_found_index (o_found_index),
        .o_found       (o_found),
        .o_status      (o_status)
    );

endmodule

// File: verif/bitmap_free_slot_finder_tb.sv
// Self-checking testbench for the bitmap free-slot finder: directed table, then random phases.
`timescale 1ns / 1ps

module bitmap_free_slot_finder_tb;
    import bfsf_pkg::*;

    localparam int WORD_BITS   = BFSF_WORD_BITS;
    localparam int MAX_WORDS   = BFSF_MAX_WORDS;
    localparam int QUIET_LIMIT = 20000;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 50;

    // op codes the block decodes as no-ops
    localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_OOR = 1'b1;

    typedef struct packed {
        logic             read_bit;
        logic [MAP_W-1:0] found_index;
        logic             found;
        logic             status;
    } slot_result_t;

    // One row of the directed table: either a map_bits write or an item.
    // Where 'typed' is set, 'res' is the hand-written result.
    typedef struct packed {
        logic             cfg_row;
        logic [MAP_W-1:0] cfg_value;
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] idx;
        logic             wv;
        logic             typed;
        slot_result_t     res;
    } step_row_t;

    localparam slot_result_t RES_ZERO = '0;

    localparam step_row_t DIRECTED_STEPS [0:26] = '{
        // full map (reset value of map_bits)
        '{1'b0, 16'd0, OP_CLEAR, 15'd0,     1'b0, 1'b1, RES_ZERO},
        '{1'b0, 16'd0, OP_READ,  15'd32767, 1'b0, 1'b1, RES_ZERO},
        '{1'b0, 16'd0, OP_FIRST, 15'd0,     1'b0, 1'b1, '{1'b0, 16'd0, 1'b1, STATUS_OK}},
        '{1'b0, 16'd0, OP_WRITE, 15'd0,     1'b1, 1'b1, RES_ZERO},
        '{1'b0, 16'd0, OP_NEXT,  15'd32767, 1'b0, 1'b0, RES_ZERO},
        '{1'b0, 16'd0, OP_SET,   15'd0,     1'b0, 1'b1, RES_ZERO},
        '{1'b0, 16'd0, OP_FIRST, 15'd0,     1'b0, 1'b1, '{1'b0, 16'd32768, 1'b0, STATUS_OK}},
        '{1'b0, 16'd0, OP_NEXT,  15'd100,   1'b0, 1'b1, '{1'b0, 16'd100, 1'b0, STATUS_OK}},
        '{1'b0, 16'd0, OP_WRITE, 15'd32767, 1'b0, 1'b1, RES_ZERO},
        // only the start bit itself is free
        '{1'b0, 16'd0, OP_NEXT,  15'd32767, 1'b0, 1'b1, '{1'b0, 16'd32767, 1'b1, STATUS_OK}},
        '{1'b0, 16'd0, OP_READ,  15'd5,     1'b0, 1'b1, '{1'b1, 16'd0, 1'b0, STATUS_OK}},
        '{1'b0, 16'd0, OP_SPARE6, 15'd32767, 1'b1, 1'b1, RES_ZERO},
        '{1'b0, 16'd0, OP_SPARE7, 15'd0,    1'b0, 1'b1, RES_ZERO},
        // empty map: everything out of range
        '{1'b1, 16'd0, OP_READ,  15'd0,     1'b0, 1'b0, RES_ZERO},
        '{1'b0, 16'd0, OP_READ,  15'd0,     1'b0, 1'b1, '{1'b0, 16'd0, 1'b0, STATUS_OOR}},
        '{1'b0, 16'd0, OP_WRITE, 15'd0,     1'b1, 1'b1, '{1'b0, 16'd0, 1'b0, STATUS_OOR}},
        '{1'b0, 16'd0, OP_NEXT,  15'd0,     1'b0, 1'b1, '{1'b0, 16'd0, 1'b0, STATUS_OOR}},
        '{1'b0, 16'd0, OP_FIRST, 15'd0,     1'b0, 1'b1, RES_ZERO},
        // one whole word plus a partial word of eight bits
        '{1'b1, 16'd40, OP_READ, 15'd0,     1'b0, 1'b0, RES_ZERO},
        '{1'b0, 16'd0, OP_WRITE, 15'd35,    1'b0, 1'b0, RES_ZERO},
        '{1'b0, 16'd0, OP_NEXT,  15'd35,    1'b0, 1'b0, RES_ZERO},
        '{1'b0, 16'd0, OP_WRITE, 15'd7,     1'b0, 1'b0, RES_ZERO},
        '{1'b0, 16'd0, OP_NEXT,  15'd35,    1'b0, 1'b0, RES_ZERO},
        '{1'b0, 16'd0, OP_NEXT,  15'd7,     1'b0, 1'b0, RES_ZERO},
        '{1'b0, 16'd0, OP_FIRST, 15'd0,     1'b0, 1'b0, RES_ZERO},
        '{1'b0, 16'd0, OP_READ,  15'd40,    1'b0, 1'b1, '{1'b0, 16'd0, 1'b0, STATUS_OOR}},
        '{1'b0, 16'd0, OP_NEXT,  15'd32767, 1'b0, 1'b1, '{1'b0, 16'd32767, 1'b0, STATUS_OOR}}
    };

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    logic [OP_W-1:0]  in_op = '0;
    logic [IDX_W-1:0] in_idx = '0;
    logic             in_wv = 1'b0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic             out_read_bit;
    logic [MAP_W-1:0] out_found_index;
    logic             out_found;
    logic             out_status;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [MAP_W-1:0] cfg_data = '0;

    bitmap_free_slot_finder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_op          (in_op),
        .i_bit_index   (in_idx),
        .i_write_value (in_wv),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_read_bit    (out_read_bit),
        .o_found_index (out_found_index),
        .o_found       (out_found),
        .o_status      (out_status),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Shadow of the block: bitmap contents, which bits hold a defined value,
    // and the map_bits register.
    bit [WORD_BITS-1:0] slot_map  [MAX_WORDS];
    bit [WORD_BITS-1:0] known_map [MAX_WORDS];
    logic [MAP_W-1:0]   map_bits_q = MAP_BITS_RST;

    slot_result_t pending_results [$];
    int mismatch_count = 0;
    int tx_gap_pct = 38;
    int rx_stall_pct = 50;
    int quiet_cycles = 0;

    // last search hit, handed to a following allocating write
    bit               alloc_due = 1'b0;
    logic [IDX_W-1:0] alloc_idx = '0;

    function automatic int used_words();
        int w;
        w = map_bits_q / WORD_BITS;
        return (w > MAX_WORDS) ? MAX_WORDS : w;
    endfunction

    // All used words fully defined, so a search touches no stale RAM.
    function automatic bit map_defined();
        for (int w = 0; w < used_words(); w++) begin
            if (known_map[w] != '1) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Circular scan over used bits, from 'start'; -1 if every bit is taken.
    function automatic int scan_free(int start, int span);
        int p;
        for (int k = 0; k < span; k++) begin
            p = (start + k) % span;
            if (!slot_map[p / WORD_BITS][p % WORD_BITS]) return p;
        end
        return -1;
    endfunction

    // Applies one operation to the shadow map and returns its result.
    task automatic predict_slot_op(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                                   input logic wv, output slot_result_t r);
        int  span;
        int  hit;
        int  w;
        bit  oor;
        r    = '0;
        span = used_words() * WORD_BITS;
        w    = idx / WORD_BITS;
        oor  = (idx >= map_bits_q) || (w >= MAX_WORDS);
        case (op)
            OP_READ: begin
                if (oor) r.status = STATUS_OOR;
                else r.read_bit = slot_map[w][idx % WORD_BITS];
            end
            OP_WRITE: begin
                if (oor) begin
                    r.status = STATUS_OOR;
                end else begin
                    slot_map[w][idx % WORD_BITS]  = wv;
                    known_map[w][idx % WORD_BITS] = 1'b1;
                end
            end
            OP_CLEAR, OP_SET: begin
                for (int i = 0; i < used_words(); i++) begin
                    slot_map[i]  = (op == OP_SET) ? '1 : '0;
                    known_map[i] = '1;
                end
            end
            OP_FIRST: begin
                r.found_index = map_bits_q;
                hit = scan_free(0, span);
                if (hit >= 0) begin
                    r.found_index = MAP_W'(hit);
                    r.found       = 1'b1;
                end
            end
            OP_NEXT: begin
                r.found_index = MAP_W'(idx);
                if (oor) begin
                    r.status = STATUS_OOR;
                end else begin
                    // a start in the partial word scans from bit 0
                    hit = scan_free((idx < span) ? idx + 1 : 0, span);
                    if (hit >= 0) begin
                        r.found_index = MAP_W'(hit);
                        r.found       = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    endtask

    // Random item, kept clear of never-written bits.
    task automatic pick_item(output logic [OP_W-1:0] op, output logic [IDX_W-1:0] idx,
                             output logic wv);
        int roll;
        int upper;
        bit in_range;
        roll  = $urandom_range(99);
        upper = map_bits_q + 40;
        if (upper > 32767) upper = 32767;
        idx = ($urandom_range(99) < 15) ? IDX_W'($urandom) : IDX_W'($urandom_range(upper));
        wv  = 1'($urandom_range(1));
        if (alloc_due) begin
            // claim the slot that the last search handed out
            op        = OP_WRITE;
            idx       = alloc_idx;
            wv        = 1'b1;
            alloc_due = 1'b0;
            return;
        end
        if (roll < 18)      op = OP_READ;
        else if (roll < 44) op = OP_WRITE;
        else if (roll < 60) op = OP_FIRST;
        else if (roll < 84) op = OP_NEXT;
        else if (roll < 88) op = OP_CLEAR;
        else if (roll < 92) op = OP_SET;
        else                op = $urandom_range(1) ? OP_SPARE6 : OP_SPARE7;
        in_range = idx < map_bits_q;
        if (op == OP_READ && in_range && !known_map[idx / WORD_BITS][idx % WORD_BITS])
            op = OP_WRITE;
        if ((op == OP_FIRST || (op == OP_NEXT && in_range)) && !map_defined())
            op = $urandom_range(1) ? OP_SET : OP_CLEAR;
    endtask

    // Presents one item and holds it until taken; valid stays high on return.
    task automatic send_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                             input logic wv, input slot_result_t want);
        while ($urandom_range(99) < tx_gap_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_op    <= op;
        in_idx   <= idx;
        in_wv    <= wv;
        do @(posedge i_clk); while (in_stall);
        pending_results.push_back(want);
    endtask

    // Drops valid and waits until every outstanding result has been taken.
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // map_bits is only written with the block idle.
    task automatic write_map_bits(input logic [MAP_W-1:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid  <= 1'b0;
        map_bits_q  = value;
        alloc_due   = 1'b0;
    endtask

    function automatic void note_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("mismatch: %s", msg);
    endfunction

    function automatic void check_field(string name, logic [MAP_W-1:0] want,
                                        logic [MAP_W-1:0] got);
        if (got !== want)
            note_mismatch($sformatf("%s expected %0d, got %0d", name, want, got));
    endfunction

    // Result side: check each accepted result against the oldest expectation,
    // then draw the stall for the next cycle.
    always @(posedge i_clk) begin : result_check
        slot_result_t want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                note_mismatch($sformatf("result with nothing expected, found_index %0d",
                                        out_found_index));
            end else begin
                want = pending_results.pop_front();
                check_field("read_bit", MAP_W'(want.read_bit), MAP_W'(out_read_bit));
                check_field("found_index", want.found_index, out_found_index);
                check_field("found", MAP_W'(want.found), MAP_W'(out_found));
                check_field("status", MAP_W'(want.status), MAP_W'(out_status));
            end
        end
        out_stall <= i_rst_n ? ($urandom_range(99) < rx_stall_pct) : 1'b0;
    end

    // Watchdog: too long without any handshake means the block has hung.
    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin : stimulus
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] idx;
        logic             wv;
        logic [MAP_W-1:0] map_value;
        slot_result_t     want;
        int               item_count;
        item_count = 0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table: extremes, every op, out of range, wrap and partial word.
        foreach (DIRECTED_STEPS[i]) begin
            if (DIRECTED_STEPS[i].cfg_row) begin
                write_map_bits(DIRECTED_STEPS[i].cfg_value);
            end else begin
                predict_slot_op(DIRECTED_STEPS[i].op, DIRECTED_STEPS[i].idx,
                                DIRECTED_STEPS[i].wv, want);
                if (DIRECTED_STEPS[i].typed) want = DIRECTED_STEPS[i].res;
                send_item(DIRECTED_STEPS[i].op, DIRECTED_STEPS[i].idx,
                          DIRECTED_STEPS[i].wv, want);
            end
        end

        // Random phases, each under its own map size. Mostly small maps so that
        // searches stay short; one empty map and one full map.
        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase == 3)                 map_value = '0;
            else if (phase == 7)            map_value = MAP_BITS_RST;
            else if ($urandom_range(99) < 65) map_value = MAP_W'($urandom_range(320));
            else                            map_value = MAP_W'($urandom_range(2048, 321));
            write_map_bits(map_value);

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // receiver-heavy stalls, then sender-heavy gaps, then flat out
                if (item_count < 167) begin
                    tx_gap_pct   = 38;
                    rx_stall_pct = 50;
                end else if (item_count < 334) begin
                    tx_gap_pct   = 50;
                    rx_stall_pct = 38;
                end else begin
                    tx_gap_pct   = 0;
                    rx_stall_pct = 0;
                end

                if (n == 0) begin
                    // software initialises the map before use
                    op  = $urandom_range(1) ? OP_SET : OP_CLEAR;
                    idx = IDX_W'($urandom);
                    wv  = 1'($urandom_range(1));
                end else begin
                    pick_item(op, idx, wv);
                    if ($urandom_range(99) < 2) drain_results();
                end

                predict_slot_op(op, idx, wv, want);
                if ((op == OP_FIRST || op == OP_NEXT) && want.found) begin
                    alloc_idx = IDX_W'(want.found_index);
                    alloc_due = $urandom_range(99) < 60;
                end
                send_item(op, idx, wv, want);
                item_count++;
            end
        end

        drain_results();
        repeat (64) @(posedge i_clk);
        if (pending_results.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", pending_results.size()));

        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
